[src/dmac_pkg.sv]
package dmac_pkg;

  localparam int unsigned NCH = 4;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_PIN   = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  localparam logic [3:0] REG_STATUS  = 4'd8;
  localparam logic [3:0] REG_REQUEST = 4'd9;
  localparam logic [3:0] REG_SMASK   = 4'd10;
  localparam logic [3:0] REG_MODE    = 4'd11;
  localparam logic [3:0] REG_CLRFF   = 4'd12;
  localparam logic [3:0] REG_MCLR    = 4'd13;
  localparam logic [3:0] REG_CLRMASK = 4'd14;
  localparam logic [3:0] REG_ALLMASK = 4'd15;

  localparam logic [2:0] BUS_NONE   = 3'd0;
  localparam logic [2:0] BUS_D2M    = 3'd1;
  localparam logic [2:0] BUS_M2D    = 3'd2;
  localparam logic [2:0] BUS_VERIFY = 3'd3;
  localparam logic [2:0] BUS_M2M    = 3'd4;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] reg_index;
    logic [7:0] write_value;
    logic [1:0] pin_channel;
    logic       pin_asserted;
    logic [7:0] bus_data;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        cycle_ran;
    logic [1:0]  cycle_channel;
    logic [15:0] target_address;
    logic [15:0] source_address;
    logic [2:0]  bus_operation;
    logic [7:0]  write_data;
    logic        tc_hit;
    logic [3:0]  dack_levels;
    logic [3:0]  dreq_levels;
  } result_t;

  // decoded item from the front part
  typedef struct packed {
    logic        is_read;
    logic        is_write;
    logic        is_pin;
    logic        is_tick;
    logic        idx_lo;      // register 0..7
    logic [1:0]  chan;        // channel of register 0..7
    logic        is_cnt;      // odd register
    item_t       item;
  } cmd_t;

endpackage

[src/dmac_if.sv]
interface dmac_item_if;
  logic             valid;
  logic             ready;
  dmac_pkg::item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dmac_result_if;
  logic               valid;
  logic               ready;
  dmac_pkg::result_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/dmac_front.sv]
module dmac_front (
  input  logic            clk,
  input  logic            rst_n,
  dmac_item_if.sink       in_ch,
  output logic            q_valid,
  output dmac_pkg::cmd_t  q_data,
  input  logic            q_ready
);

  // two-entry queue of decoded items
  dmac_pkg::cmd_t ent_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_r, wr_nxt;
  dmac_pkg::cmd_t dec;
  logic push, pop;

  always_comb begin
    dec.item     = in_ch.data;
    dec.is_read  = in_ch.data.mode == dmac_pkg::OP_READ;
    dec.is_write = in_ch.data.mode == dmac_pkg::OP_WRITE;
    dec.is_pin   = in_ch.data.mode == dmac_pkg::OP_PIN;
    dec.is_tick  = in_ch.data.mode == dmac_pkg::OP_TICK;
    dec.idx_lo   = ~in_ch.data.reg_index[3];
    dec.chan     = in_ch.data.reg_index[2:1];
    dec.is_cnt   = in_ch.data.reg_index[0];
  end

  assign in_ch.ready = cnt_r != 2'd2;
  assign push    = in_ch.valid & in_ch.ready;
  assign q_valid = cnt_r != 2'd0;
  assign pop     = q_valid & q_ready;
  assign q_data  = ent_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
    rd_nxt  = rd_r ^ pop;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (push) ent_r[wr_r] <= dec;
  end

endmodule

[src/dmac_back.sv]
module dmac_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  dmac_pkg::cmd_t   q_data,
  output logic             q_ready,
  dmac_result_if.source    out_ch
);

  logic [15:0] base_addr_r [4];
  logic [15:0] base_cnt_r  [4];
  logic [15:0] cur_addr_r  [4];
  logic [15:0] cur_cnt_r   [4];
  logic [7:0]  cmode_r     [4];
  logic [15:0] base_addr_nxt [4];
  logic [15:0] base_cnt_nxt  [4];
  logic [15:0] cur_addr_nxt  [4];
  logic [15:0] cur_cnt_nxt   [4];
  logic [7:0]  cmode_nxt     [4];
  logic [7:0]  command_r, command_nxt;
  logic [3:0]  status_r, status_nxt;
  logic [3:0]  soft_r, soft_nxt;
  logic [3:0]  mask_r, mask_nxt;
  logic [3:0]  pin_r, pin_nxt;
  logic [7:0]  temp_r, temp_nxt;
  logic        high_r, high_nxt;

  dmac_pkg::result_t res_r, res_nxt;
  logic              ov_r;
  logic              step;

  dmac_pkg::item_t it;
  logic [3:0]  asking, ask_post, bitv;
  logic [1:0]  pc, tc;
  logic        pc_ok, post_ok, tcx;
  logic [15:0] rv, a, wrd;
  logic [1:0]  ty;
  logic [7:0]  m;

  assign it      = q_data.item;
  assign q_ready = !ov_r || out_ch.ready;
  assign step    = q_valid && q_ready;
  assign out_ch.valid = ov_r;
  assign out_ch.data  = res_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      asking[c] = (pin_r[c] & ~mask_r[c]) | (soft_r[c] & (cmode_r[c][7:6] == 2'd2));
    end
    pc_ok = !command_r[2] && asking != 4'd0;
    priority casez (asking)
      4'b???1: pc = 2'd0;
      4'b??10: pc = 2'd1;
      4'b?100: pc = 2'd2;
      default: pc = 2'd3;
    endcase
  end

  always_comb begin
    base_addr_nxt = base_addr_r; base_cnt_nxt = base_cnt_r;
    cur_addr_nxt  = cur_addr_r;  cur_cnt_nxt  = cur_cnt_r;
    cmode_nxt = cmode_r; command_nxt = command_r; status_nxt = status_r;
    soft_nxt = soft_r; mask_nxt = mask_r; pin_nxt = pin_r;
    temp_nxt = temp_r; high_nxt = high_r;
    res_nxt = '0;
    bitv = 4'b1 << it.write_value[1:0];
    rv = q_data.is_cnt ? cur_cnt_r[q_data.chan] : cur_addr_r[q_data.chan];
    wrd = q_data.is_cnt ? base_cnt_r[q_data.chan] : base_addr_r[q_data.chan];
    tc = pc; tcx = 1'b0;
    m = cmode_r[pc]; ty = m[3:2]; a = cur_addr_r[pc];

    if (q_data.is_read) begin
      if (q_data.idx_lo) begin
        res_nxt.read_data = high_r ? rv[15:8] : rv[7:0];
        high_nxt = !high_r;
      end else if (it.reg_index == dmac_pkg::REG_STATUS) begin
        res_nxt.read_data = {asking, status_r};
        status_nxt = '0;
      end else if (it.reg_index == dmac_pkg::REG_MCLR) begin
        res_nxt.read_data = temp_r;
      end
    end else if (q_data.is_write) begin
      if (q_data.idx_lo) begin
        if (high_r) wrd[15:8] = it.write_value;
        else wrd[7:0] = it.write_value;
        if (q_data.is_cnt) begin
          base_cnt_nxt[q_data.chan] = wrd; cur_cnt_nxt[q_data.chan] = wrd;
        end else begin
          base_addr_nxt[q_data.chan] = wrd; cur_addr_nxt[q_data.chan] = wrd;
        end
        high_nxt = !high_r;
      end else begin
        unique case (it.reg_index)
          dmac_pkg::REG_STATUS:  command_nxt = it.write_value;
          dmac_pkg::REG_REQUEST: soft_nxt = it.write_value[2] ? (soft_r | bitv)
                                                              : (soft_r & ~bitv);
          dmac_pkg::REG_SMASK:   mask_nxt = it.write_value[2] ? (mask_r | bitv)
                                                              : (mask_r & ~bitv);
          dmac_pkg::REG_MODE:    cmode_nxt[it.write_value[1:0]] = it.write_value;
          dmac_pkg::REG_CLRFF:   high_nxt = 1'b0;
          dmac_pkg::REG_MCLR: begin
            for (int c = 0; c < 4; c++) begin
              base_addr_nxt[c] = '0; base_cnt_nxt[c] = '0;
              cur_addr_nxt[c] = '0; cur_cnt_nxt[c] = '0; cmode_nxt[c] = '0;
            end
            command_nxt = '0; status_nxt = '0; soft_nxt = '0; mask_nxt = 4'hF;
            pin_nxt = '0; temp_nxt = '0; high_nxt = 1'b0;
          end
          dmac_pkg::REG_CLRMASK: mask_nxt = '0;
          dmac_pkg::REG_ALLMASK: mask_nxt = it.write_value[3:0];
          default: ;
        endcase
      end
    end else if (q_data.is_pin) begin
      pin_nxt[it.pin_channel] = it.pin_asserted;
    end else if (command_r[0]) begin
      // memory-to-memory: channel 0 source, channel 1 destination
      if (!command_r[2] && asking[0]) begin
        temp_nxt = it.bus_data;
        if (!command_r[1])
          cur_addr_nxt[0] = cmode_r[0][5] ? cur_addr_r[0] - 16'd1 : cur_addr_r[0] + 16'd1;
        cur_addr_nxt[1] = cmode_r[1][5] ? cur_addr_r[1] - 16'd1 : cur_addr_r[1] + 16'd1;
        cur_cnt_nxt[1] = cur_cnt_r[1] - 16'd1;
        tcx = cur_cnt_r[1] == 16'd0;
        tc = 2'd1;
        res_nxt.cycle_ran = 1'b1; res_nxt.cycle_channel = 2'd1;
        res_nxt.target_address = cur_addr_r[1];
        res_nxt.source_address = cur_addr_r[0];
        res_nxt.bus_operation = dmac_pkg::BUS_M2M;
        res_nxt.write_data = it.bus_data;
        res_nxt.tc_hit = tcx;
        if (tcx) soft_nxt[0] = 1'b0;
      end
    end else if (pc_ok && m[7:6] != 2'd3 && ty != 2'd3) begin
      unique case (ty)
        2'd1: begin
          res_nxt.bus_operation = dmac_pkg::BUS_D2M; res_nxt.write_data = it.bus_data;
        end
        2'd2: begin
          res_nxt.bus_operation = dmac_pkg::BUS_M2D; res_nxt.write_data = it.bus_data;
          res_nxt.source_address = a;
        end
        default: res_nxt.bus_operation = dmac_pkg::BUS_VERIFY;
      endcase
      cur_addr_nxt[pc] = m[5] ? a - 16'd1 : a + 16'd1;
      cur_cnt_nxt[pc] = cur_cnt_r[pc] - 16'd1;
      tcx = cur_cnt_r[pc] == 16'd0;
      res_nxt.cycle_ran = 1'b1; res_nxt.cycle_channel = pc;
      res_nxt.target_address = a; res_nxt.tc_hit = tcx;
    end

    // terminal count handling; soft clear above is folded in after
    if (tcx) begin
      status_nxt[tc] = 1'b1;
      soft_nxt[tc] = 1'b0;
      if (cmode_r[tc][4]) begin
        cur_addr_nxt[tc] = base_addr_r[tc];
        cur_cnt_nxt[tc] = base_cnt_r[tc];
      end else begin
        mask_nxt[tc] = 1'b1;
      end
    end

    // pin levels from the state after this step
    for (int c = 0; c < 4; c++) begin
      ask_post[c] = (pin_nxt[c] & ~mask_nxt[c]) | (soft_nxt[c] & (cmode_nxt[c][7:6] == 2'd2));
    end
    post_ok = !command_nxt[2];
    for (int c = 0; c < 4; c++) begin
      logic ack;
      ack = post_ok && ask_post[c] && ((ask_post & ((4'b1 << c) - 4'b1)) == 4'd0);
      res_nxt.dack_levels[c] = command_nxt[7] ? ack : !ack;
      res_nxt.dreq_levels[c] = command_nxt[6] ? !pin_nxt[c] : pin_nxt[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 4; c++) begin
        base_addr_r[c] <= '0; base_cnt_r[c] <= '0;
        cur_addr_r[c] <= '0; cur_cnt_r[c] <= '0; cmode_r[c] <= '0;
      end
      command_r <= '0; status_r <= '0; soft_r <= '0; mask_r <= 4'hF;
      pin_r <= '0; temp_r <= '0; high_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (step) begin
        base_addr_r <= base_addr_nxt; base_cnt_r <= base_cnt_nxt;
        cur_addr_r <= cur_addr_nxt; cur_cnt_r <= cur_cnt_nxt; cmode_r <= cmode_nxt;
        command_r <= command_nxt; status_r <= status_nxt; soft_r <= soft_nxt;
        mask_r <= mask_nxt; pin_r <= pin_nxt; temp_r <= temp_nxt; high_r <= high_nxt;
      end
      if (step) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
    end
    if (step) res_r <= res_nxt;
  end

endmodule

[src/dma_controller_four_channel.sv]
// four-channel 8237-style dma controller. each input beat is a register read,
// a register write, a dreq pin change or one bus-transfer tick, and gives
// exactly one result beat. a two-entry queue decodes and holds input beats;
// the execute stage applies one beat per cycle and registers its result, so
// one beat per cycle is sustained when the result side takes every beat; a
// beat passes through its queue entry and then the result register. the rate
// is set by the execute stage's combinational state update (priority pick
// plus 16-bit address and count step).
module dma_controller_four_channel #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  dmac_item_if.sink    in_ch,
  dmac_result_if.source out_ch
);

  logic           q_valid, q_ready;
  dmac_pkg::cmd_t q_data;

  // front: accept and decode
  dmac_front u_front (
    .clk, .rst_n, .in_ch, .q_valid, .q_data, .q_ready
  );

  // back: register file, priority pick and transfer
  dmac_back u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_ready, .out_ch
  );

  // every result reports cycle_ran only together with a transfer opcode
  a_ran_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.cycle_ran |-> out_ch.data.bus_operation != dmac_pkg::BUS_NONE)
    else $error("transfer without operation");

  // a held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed under stall");

  // terminal count only comes with a transfer
  a_tc: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.tc_hit |-> out_ch.data.cycle_ran)
    else $error("terminal count without cycle");

  // channel count is fixed by the register map
  a_nch: assert property (@(posedge clk) NUM_CHANNELS == dmac_pkg::NCH)
    else $error("unsupported channel count");

endmodule

[sim/dmac_checker.sv]
`timescale 1ns / 1ps

module dmac_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  logic              item_ready,
  input  dmac_pkg::item_t   item_data,
  input  logic              res_valid,
  input  logic              res_ready,
  input  dmac_pkg::result_t res_data,
  output int                fail_count,
  output int                pending
);

  localparam logic [7:0] CMD_M2M       = 8'h01;
  localparam logic [7:0] CMD_HOLD0     = 8'h02;
  localparam logic [7:0] CMD_DISABLE   = 8'h04;
  localparam logic [7:0] CMD_DREQ_LOW  = 8'h40;
  localparam logic [7:0] CMD_DACK_HIGH = 8'h80;
  localparam logic [7:0] MODE_DEC      = 8'h20;
  localparam logic [7:0] MODE_AUTO     = 8'h10;

  logic [15:0] m_base_addr [dmac_pkg::NCH];
  logic [15:0] m_base_cnt  [dmac_pkg::NCH];
  logic [15:0] m_cur_addr  [dmac_pkg::NCH];
  logic [15:0] m_cur_cnt   [dmac_pkg::NCH];
  logic [7:0]  m_chmode    [dmac_pkg::NCH];
  logic [7:0]  m_cmd;
  logic [3:0]  m_status, m_soft, m_mask, m_pins;
  logic [7:0]  m_temp;
  logic        m_hi;

  dmac_pkg::result_t expected_q[$];

  function automatic void dma_clear();
    for (int c = 0; c < dmac_pkg::NCH; c++) begin
      m_base_addr[c] = '0; m_base_cnt[c] = '0;
      m_cur_addr[c] = '0;  m_cur_cnt[c] = '0; m_chmode[c] = '0;
    end
    m_cmd = '0; m_status = '0; m_soft = '0; m_mask = 4'hF;
    m_pins = '0; m_temp = '0; m_hi = 1'b0;
  endfunction

  function automatic logic [3:0] asking();
    logic [3:0] sw;
    sw = '0;
    for (int c = 0; c < dmac_pkg::NCH; c++)
      if (m_soft[c] && m_chmode[c][7:6] == 2'd2) sw[c] = 1'b1;
    return (m_pins & ~m_mask) | sw;
  endfunction

  function automatic int winner();
    logic [3:0] a;
    if (m_cmd & CMD_DISABLE) return -1;
    a = asking();
    for (int c = 0; c < dmac_pkg::NCH; c++) if (a[c]) return c;
    return -1;
  endfunction

  function automatic logic [15:0] next_addr(logic [15:0] a, logic [7:0] m);
    return (m & MODE_DEC) ? a - 16'd1 : a + 16'd1;
  endfunction

  function automatic void terminal(int c);
    m_status[c] = 1'b1;
    m_soft[c] = 1'b0;
    if (m_chmode[c] & MODE_AUTO) begin
      m_cur_addr[c] = m_base_addr[c];
      m_cur_cnt[c] = m_base_cnt[c];
    end else m_mask[c] = 1'b1;
  endfunction

  function automatic dmac_pkg::result_t dma_step(dmac_pkg::item_t it);
    dmac_pkg::result_t r;
    int p, c;
    logic [15:0] v, a, from, to;
    logic [1:0] ty;
    logic [3:0] ak;
    logic tc;
    r = '0;
    case (dmac_pkg::op_t'(it.mode))
      dmac_pkg::OP_READ: begin
        if (it.reg_index < 4'd8) begin
          c = int'(it.reg_index[2:1]);
          v = it.reg_index[0] ? m_cur_cnt[c] : m_cur_addr[c];
          r.read_data = m_hi ? v[15:8] : v[7:0];
          m_hi = !m_hi;
        end else if (it.reg_index == dmac_pkg::REG_STATUS) begin
          r.read_data = {asking(), m_status};
          m_status = '0;
        end else if (it.reg_index == dmac_pkg::REG_MCLR) r.read_data = m_temp;
      end
      dmac_pkg::OP_WRITE: begin
        if (it.reg_index < 4'd8) begin
          c = int'(it.reg_index[2:1]);
          if (it.reg_index[0]) begin
            if (m_hi) m_base_cnt[c][15:8] = it.write_value;
            else m_base_cnt[c][7:0] = it.write_value;
            m_cur_cnt[c] = m_base_cnt[c];
          end else begin
            if (m_hi) m_base_addr[c][15:8] = it.write_value;
            else m_base_addr[c][7:0] = it.write_value;
            m_cur_addr[c] = m_base_addr[c];
          end
          m_hi = !m_hi;
        end else begin
          case (it.reg_index)
            dmac_pkg::REG_STATUS:  m_cmd = it.write_value;
            dmac_pkg::REG_REQUEST: m_soft[it.write_value[1:0]] = it.write_value[2];
            dmac_pkg::REG_SMASK:   m_mask[it.write_value[1:0]] = it.write_value[2];
            dmac_pkg::REG_MODE:    m_chmode[it.write_value[1:0]] = it.write_value;
            dmac_pkg::REG_CLRFF:   m_hi = 1'b0;
            dmac_pkg::REG_MCLR:    dma_clear();
            dmac_pkg::REG_CLRMASK: m_mask = '0;
            default:               m_mask = it.write_value[3:0];
          endcase
        end
      end
      dmac_pkg::OP_PIN: m_pins[it.pin_channel] = it.pin_asserted;
      default: begin
        if (m_cmd & CMD_M2M) begin
          ak = asking();
          if (!(m_cmd & CMD_DISABLE) && ak[0]) begin
            from = m_cur_addr[0];
            to = m_cur_addr[1];
            m_temp = it.bus_data;
            if (!(m_cmd & CMD_HOLD0)) m_cur_addr[0] = next_addr(from, m_chmode[0]);
            m_cur_addr[1] = next_addr(to, m_chmode[1]);
            tc = m_cur_cnt[1] == 16'd0;
            m_cur_cnt[1] = m_cur_cnt[1] - 16'd1;
            r.cycle_ran = 1'b1; r.cycle_channel = 2'd1;
            r.target_address = to; r.source_address = from;
            r.bus_operation = dmac_pkg::BUS_M2M; r.write_data = m_temp;
            r.tc_hit = tc;
            if (tc) begin
              terminal(1);
              m_soft[0] = 1'b0;
            end
          end
        end else begin
          p = winner();
          if (p >= 0 && m_chmode[p][7:6] != 2'd3 && m_chmode[p][3:2] != 2'd3) begin
            ty = m_chmode[p][3:2];
            a = m_cur_addr[p];
            if (ty == 2'd1) begin
              r.bus_operation = dmac_pkg::BUS_D2M; r.write_data = it.bus_data;
            end else if (ty == 2'd2) begin
              r.bus_operation = dmac_pkg::BUS_M2D; r.write_data = it.bus_data;
              r.source_address = a;
            end else r.bus_operation = dmac_pkg::BUS_VERIFY;
            m_cur_addr[p] = next_addr(a, m_chmode[p]);
            tc = m_cur_cnt[p] == 16'd0;
            m_cur_cnt[p] = m_cur_cnt[p] - 16'd1;
            r.cycle_ran = 1'b1; r.cycle_channel = 2'(p);
            r.target_address = a; r.tc_hit = tc;
            if (tc) terminal(p);
          end
        end
      end
    endcase
    p = winner();
    for (int k = 0; k < dmac_pkg::NCH; k++) begin
      r.dack_levels[k] = (m_cmd & CMD_DACK_HIGH) ? (p == k) : (p != k);
      r.dreq_levels[k] = (m_cmd & CMD_DREQ_LOW) ? !m_pins[k] : m_pins[k];
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    dmac_pkg::result_t e;
    if (!rst_n) begin
      dma_clear();
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (item_valid && item_ready) expected_q.push_back(dma_step(item_data));
      if (res_valid && res_ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %h", res_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== res_data) begin
            if (fail_count < 10) $display("mismatch: expected %h got %h", e, res_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending;
  int   send_idle_pct, recv_stall_pct;

  dmac_item_if   in_ch ();
  dmac_result_if out_ch ();

  dma_controller_four_channel dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // checker sees every beat on both channels
  dmac_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(in_ch.valid),
    .item_ready(in_ch.ready),
    .item_data (in_ch.data),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res_data  (out_ch.data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver stalls at the rate of the current phase
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // hands one beat to the block, idling first at the phase's rate
  task automatic send_beat(dmac_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic reg_write(logic [3:0] r, logic [7:0] v);
    dmac_pkg::item_t it;
    it = dmac_pkg::item_t'($urandom);
    it.mode = dmac_pkg::OP_WRITE; it.reg_index = r; it.write_value = v;
    send_beat(it);
  endtask

  task automatic reg_read(logic [3:0] r);
    dmac_pkg::item_t it;
    it = dmac_pkg::item_t'($urandom);
    it.mode = dmac_pkg::OP_READ; it.reg_index = r;
    send_beat(it);
  endtask

  task automatic set_pin(logic [1:0] c, logic lvl);
    dmac_pkg::item_t it;
    it = dmac_pkg::item_t'($urandom);
    it.mode = dmac_pkg::OP_PIN; it.pin_channel = c; it.pin_asserted = lvl;
    send_beat(it);
  endtask

  task automatic bus_tick();
    dmac_pkg::item_t it;
    it = dmac_pkg::item_t'($urandom);
    it.mode = dmac_pkg::OP_TICK;
    send_beat(it);
  endtask

  // programs one channel with small counts so terminal count comes often
  task automatic setup_channel(logic [1:0] c);
    logic [7:0] md;
    md = 8'($urandom);
    md[1:0] = c;
    if ($urandom_range(9) < 8) md[3:2] = 2'($urandom_range(2));
    if ($urandom_range(9) < 8) md[7:6] = 2'($urandom_range(2));
    reg_write(dmac_pkg::REG_MODE, md);
    reg_write(dmac_pkg::REG_CLRFF, 8'h00);
    reg_write({1'b0, c, 1'b0}, 8'($urandom));
    reg_write({1'b0, c, 1'b0}, 8'($urandom));
    reg_write({1'b0, c, 1'b1}, 8'($urandom_range(6)));
    reg_write({1'b0, c, 1'b1}, ($urandom_range(7) == 0) ? 8'hFF : 8'h00);
    reg_write(dmac_pkg::REG_SMASK, {5'd0, 1'b0, c});
  endtask

  task automatic random_beat();
    int k;
    logic [7:0] v;
    k = $urandom_range(99);
    if (k < 45) bus_tick();
    else if (k < 60) set_pin(2'($urandom), 1'($urandom));
    else if (k < 75) reg_read(4'($urandom));
    else if (k < 80) setup_channel(2'($urandom));
    else begin
      v = 8'($urandom);
      case ($urandom_range(7))
        0: begin
          // keep memory-to-memory and disable less frequent
          v[0] = ($urandom_range(3) == 0);
          v[2] = ($urandom_range(7) == 0);
          reg_write(dmac_pkg::REG_STATUS, v);
        end
        1: reg_write(dmac_pkg::REG_REQUEST, v);
        2: reg_write(dmac_pkg::REG_SMASK, v);
        3: reg_write(dmac_pkg::REG_CLRMASK, v);
        4: reg_write(dmac_pkg::REG_ALLMASK, v);
        5: reg_write(($urandom_range(40) == 0) ? dmac_pkg::REG_MCLR : dmac_pkg::REG_CLRFF, v);
        default: reg_write(4'($urandom_range(7)), v);
      endcase
    end
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset reads, control and channel register writes, transfer ticks
    reg_read(dmac_pkg::REG_STATUS);
    reg_read(4'd0);
    reg_read(dmac_pkg::REG_MCLR);
    reg_read(dmac_pkg::REG_REQUEST);
    reg_write(dmac_pkg::REG_STATUS, 8'hC0);
    set_pin(2'd2, 1'b1);
    setup_channel(2'd2);
    bus_tick();
    bus_tick();
    reg_write(dmac_pkg::REG_REQUEST, 8'h07);
    reg_write(dmac_pkg::REG_MODE, 8'h80);
    bus_tick();
    reg_write(dmac_pkg::REG_STATUS, 8'h03);
    bus_tick();
    reg_write(dmac_pkg::REG_STATUS, 8'h04);
    bus_tick();
    reg_write(dmac_pkg::REG_ALLMASK, 8'hFF);
    reg_write(dmac_pkg::REG_CLRMASK, 8'h00);
    reg_read(dmac_pkg::REG_STATUS);
    reg_write(dmac_pkg::REG_MCLR, 8'h00);
    reg_read(4'd7);

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 80 : (ph == 3) ? 24 : 0;
      recv_stall_pct = (ph == 2) ? 80 : (ph == 3) ? 24 : 0;
      for (int n = 0; n < 270; n++) begin
        random_beat();
        if (n == 135) begin
          // sender holds off until every result is back
          in_ch.valid <= 1'b0;
          @(posedge clk);
          wait_drained();
        end
      end
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait_drained();
    repeat (10) @(posedge clk);

    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #60ms;
    $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
src/dmac_pkg.sv
src/dmac_if.sv
src/dmac_front.sv
src/dmac_back.sv
src/dma_controller_four_channel.sv
sim/dmac_checker.sv
sim/tb_top.sv
